// ----- rtl/pwvm_pkg.sv -----
// ----------------------------------------------------------------------------
// pwvm_pkg: shared types and constants for the wavetable voice mixer
// Voice word layout, sequencer states, opcode/status codes, step table
// and the waveform lookup.
// ----------------------------------------------------------------------------
package pwvm_pkg;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_NOTE = 1'b1;

    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;

    localparam logic [1:0] WAVE_TRI  = 2'd0;
    localparam logic [1:0] WAVE_SQ50 = 2'd1;
    localparam logic [1:0] WAVE_SQ25 = 2'd2;
    localparam logic [1:0] WAVE_RESET = WAVE_SQ25;

    localparam int PHASE_FULL = 131071;
    localparam int RATE_HZ    = 32000;
    localparam int MIX_MAX    = 262143;
    localparam int MIX_MIN    = -262144;
    localparam int MIX_W      = 19;

    typedef struct packed {
        logic [15:0] phase;
        logic [6:0]  note;
        logic [6:0]  level;
    } voice_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_FIRST  = 5'b00010,
        ST_RUN    = 5'b00100,
        ST_ASSIGN = 5'b01000,
        ST_DONE   = 5'b10000
    } seq_state_t;

    // integer part of the equal-tempered note frequency in Hz
    localparam logic [13:0] NOTE_HZ [128] = '{
        14'd8, 14'd8, 14'd9, 14'd9, 14'd10, 14'd10, 14'd11, 14'd12,
        14'd12, 14'd13, 14'd14, 14'd15,
        14'd16, 14'd17, 14'd18, 14'd19, 14'd20, 14'd21, 14'd23, 14'd24,
        14'd25, 14'd27, 14'd29, 14'd30,
        14'd32, 14'd34, 14'd36, 14'd38, 14'd41, 14'd43, 14'd46, 14'd48,
        14'd51, 14'd55, 14'd58, 14'd61,
        14'd65, 14'd69, 14'd73, 14'd77, 14'd82, 14'd87, 14'd92, 14'd97,
        14'd103, 14'd110, 14'd116, 14'd123,
        14'd130, 14'd138, 14'd146, 14'd155, 14'd164, 14'd174, 14'd184, 14'd195,
        14'd207, 14'd220, 14'd233, 14'd246,
        14'd261, 14'd277, 14'd293, 14'd311, 14'd329, 14'd349, 14'd369, 14'd391,
        14'd415, 14'd440, 14'd466, 14'd493,
        14'd523, 14'd554, 14'd587, 14'd622, 14'd659, 14'd698, 14'd739, 14'd783,
        14'd830, 14'd880, 14'd932, 14'd987,
        14'd1046, 14'd1108, 14'd1174, 14'd1244, 14'd1318, 14'd1396, 14'd1479,
        14'd1567, 14'd1661, 14'd1760, 14'd1864, 14'd1975,
        14'd2093, 14'd2217, 14'd2349, 14'd2489, 14'd2637, 14'd2793, 14'd2959,
        14'd3135, 14'd3322, 14'd3520, 14'd3729, 14'd3951,
        14'd4186, 14'd4434, 14'd4698, 14'd4978, 14'd5274, 14'd5587, 14'd5919,
        14'd6271, 14'd6644, 14'd7040, 14'd7458, 14'd7902,
        14'd8372, 14'd8869, 14'd9397, 14'd9956, 14'd10548, 14'd11175, 14'd11839,
        14'd12543
    };

    typedef logic [15:0] step_rom_t [128];

    // evaluated at elaboration only
    function automatic step_rom_t build_step_rom();
        step_rom_t   rom;
        logic [31:0] prod;
        for (int n = 0; n < 128; n++) begin
            prod   = 32'(NOTE_HZ[n]) * 32'(PHASE_FULL);
            rom[n] = 16'(prod / RATE_HZ);
        end
        return rom;
    endfunction

    localparam step_rom_t STEP_ROM = build_step_rom();

    // top2: two msbs of the phase; frac: phase[14:0] with bits below the
    // table index cleared, i.e. (index mod half-table) * step size
    function automatic logic signed [16:0] table_value(
        input logic [1:0]  sel,
        input logic [1:0]  top2,
        input logic [14:0] frac
    );
        logic signed [16:0] f;
        logic signed [16:0] tri_v;
        logic signed [16:0] sq50;
        logic signed [16:0] sq25;
        logic signed [16:0] res;
        f = $signed({2'b00, frac});
        unique case (top2)
            2'b10:   tri_v = 17'sd16383 - f;
            2'b11:   tri_v = 17'sd16384 - f;
            default: tri_v = f - 17'sd16384;
        endcase
        sq50 = top2[1] ? 17'sd16383 : -17'sd16384;
        sq25 = (top2 == 2'b11) ? 17'sd16383 : -17'sd16384;
        unique case (sel)
            WAVE_TRI:  res = tri_v;
            WAVE_SQ50: res = sq50;
            default:   res = sq25;
        endcase
        return res;
    endfunction

endpackage

// ----- rtl/pwvm_ram.sv -----
// ----------------------------------------------------------------------------
// pwvm_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pwvm_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/poly_wavetable_voice_mixer.sv -----
// ----------------------------------------------------------------------------
// poly_wavetable_voice_mixer: polyphonic wavetable synthesizer with mixer
// Note events update the voice table; sample ticks sum the active voices'
// waveform values and advance their phases, one voice per cycle.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid, in_ready, opcode, status,       | input
//           | note_number, velocity                     |
//  out      | out_valid, out_ready, mix_sample          | output
//  cfg      | cfg_valid, cfg_ready, cfg_data            | input
//
//  From one accepted request to the next, a tick passes a RAM read lead-in state,
//  a pass at one voice per cycle through the shared adder and RAM write port,
//  a wrap-up state and the idle state; a note on/off takes the same path with
//  no wrap-up, and an unmatched note on that claims a voice adds a write state.
//  Other status bytes are taken in the idle state and change nothing.
//  A finished tick waits in the wrap-up state only while a previous sample
//  is still held on the output. Voice state comes out of reset cleared by
//  per-voice valid bits, with no clearing pass. cfg_ready is always high.
// ----------------------------------------------------------------------------
module poly_wavetable_voice_mixer #(
    parameter int VOICES     = 16,
    parameter int TABLE_BITS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic [7:0]                    status,
    input  logic [6:0]                    note_number,
    input  logic [6:0]                    velocity,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [pwvm_pkg::MIX_W-1:0] mix_sample,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_data
);

    import pwvm_pkg::*;

    localparam int VW       = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int ACC_RAW  = 17 + $clog2(VOICES + 1);
    localparam int ACC_W    = (ACC_RAW < MIX_W) ? MIX_W : ACC_RAW;
    localparam logic [VW-1:0] LAST_IDX = VW'(VOICES - 1);
    localparam logic [14:0] FRAC_MASK =
        15'(((1 << (TABLE_BITS - 1)) - 1) << (16 - TABLE_BITS));
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(MIX_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(MIX_MIN);

    seq_state_t              state_reg, state_next;
    logic [VW-1:0]           cnt_reg, cnt_next;
    logic                    tick_reg, tick_next;
    logic                    off_reg, off_next;
    logic [6:0]              note_reg, note_next;
    logic [6:0]              vel_reg, vel_next;
    logic                    matched_reg, matched_next;
    logic                    free_found_reg, free_found_next;
    logic [VW-1:0]           free_idx_reg, free_idx_next;
    logic [15:0]             free_phase_reg, free_phase_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    out_valid_reg, out_valid_next;
    logic [MIX_W-1:0]        mix_reg, mix_next;
    logic [1:0]              wave_sel_reg, wave_sel_next;
    logic [VOICES-1:0]       valid_reg, valid_next;

    logic                    ram_we;
    logic [VW-1:0]           ram_waddr;
    logic [VW-1:0]           ram_raddr;
    voice_t                  ram_wdata;
    logic [$bits(voice_t)-1:0] ram_rdata;

    voice_t                  cur;
    logic                    last;
    logic signed [16:0]      tv;
    logic                    done_load;

    pwvm_ram #(
        .WIDTH ($bits(voice_t)),
        .DEPTH (VOICES)
    ) u_voice_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // never-written voices read as the reset state
    assign cur  = valid_reg[cnt_reg] ? voice_t'(ram_rdata) : '0;
    assign last = (cnt_reg == LAST_IDX);
    assign tv   = table_value(wave_sel_reg, cur.phase[15:14], cur.phase[14:0] & FRAC_MASK);

    assign in_ready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign mix_sample = $signed(mix_reg);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        tick_next       = tick_reg;
        off_next        = off_reg;
        note_next       = note_reg;
        vel_next        = vel_reg;
        matched_next    = matched_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        free_phase_next = free_phase_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg;
        mix_next        = mix_reg;
        wave_sel_next   = wave_sel_reg;
        valid_next      = valid_reg;
        ram_we          = 1'b0;
        ram_waddr       = cnt_reg;
        ram_wdata       = cur;
        ram_raddr       = '0;
        done_load       = 1'b0;

        if (cfg_valid)
        begin
            wave_sel_next = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    tick_next       = (opcode == OP_TICK);
                    off_next        = (status == STATUS_NOTE_OFF);
                    note_next       = note_number;
                    vel_next        = velocity;
                    matched_next    = 1'b0;
                    free_found_next = 1'b0;
                    acc_next        = '0;
                    if (opcode == OP_TICK || status == STATUS_NOTE_OFF ||
                        status == STATUS_NOTE_ON)
                    begin
                        state_next = ST_FIRST;
                    end
                end
            end
            ST_FIRST:
            begin
                ram_raddr  = '0;
                cnt_next   = '0;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                ram_raddr = last ? '0 : cnt_reg + VW'(1);
                cnt_next  = last ? cnt_reg : cnt_reg + VW'(1);
                if (tick_reg)
                begin
                    if (cur.level != 7'd0)
                    begin
                        acc_next        = acc_reg + ACC_W'(tv);
                        ram_we          = 1'b1;
                        ram_wdata.phase = cur.phase + STEP_ROM[cur.note];
                    end
                end
                else
                begin
                    if (cur.note == note_reg)
                    begin
                        matched_next    = 1'b1;
                        ram_we          = 1'b1;
                        ram_wdata.level = off_reg ? 7'd0 : vel_reg;
                    end
                    // first silent voice, judged before any update of this request
                    if (cur.level == 7'd0 && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = cnt_reg;
                        free_phase_next = cur.phase;
                    end
                end
                if (last)
                begin
                    if (tick_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (!off_reg && !matched_next && free_found_next)
                    begin
                        state_next = ST_ASSIGN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ASSIGN:
            begin
                ram_we          = 1'b1;
                ram_waddr       = free_idx_reg;
                ram_wdata.phase = free_phase_reg;
                ram_wdata.note  = note_reg;
                ram_wdata.level = vel_reg;
                state_next      = ST_IDLE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    done_load      = 1'b1;
                    out_valid_next = 1'b1;
                    if (acc_reg > SAT_HI)
                    begin
                        mix_next = SAT_HI[MIX_W-1:0];
                    end
                    else if (acc_reg < SAT_LO)
                    begin
                        mix_next = SAT_LO[MIX_W-1:0];
                    end
                    else
                    begin
                        mix_next = acc_reg[MIX_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ram_we)
        begin
            valid_next[ram_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            tick_reg       <= 1'b0;
            off_reg        <= 1'b0;
            matched_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            wave_sel_reg   <= WAVE_RESET;
            valid_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            tick_reg       <= tick_next;
            off_reg        <= off_next;
            matched_reg    <= matched_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
            wave_sel_reg   <= wave_sel_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        note_reg       <= note_next;
        vel_reg        <= vel_next;
        free_idx_reg   <= free_idx_next;
        free_phase_reg <= free_phase_next;
        acc_reg        <= acc_next;
        mix_reg        <= mix_next;
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (cnt_reg <= LAST_IDX))
        else $error("voice counter out of range");

    a_we_scope: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_RUN || state_reg == ST_ASSIGN))
        else $error("voice RAM written outside a voice pass");

    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        done_load |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("finished tick did not reach the output register");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the polyphonic wavetable voice mixer
// Drives note events and sample ticks with bursty timing against a stalling
// sink. A scoreboard mirrors the voice table and checks each mixed sample,
// across all waveform selector settings.
// ----------------------------------------------------------------------------
module tb_top;

    import pwvm_pkg::*;

    localparam int VOICES        = 16;
    localparam int TABLE_BITS    = 4;
    localparam int PHASE_COUNT   = 5;
    localparam int PHASE_ITEMS   = 186;
    localparam int SETTLE_CYCLES = 2 * (VOICES + 4);
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_REPORTS   = 40;

    localparam logic [1:0] WAVE_SPARE = 2'd3;

    // integer note frequencies in Hz, equal temperament around A4 = 440
    localparam int NOTE_FREQ [128] = '{
        8, 8, 9, 9, 10, 10, 11, 12, 12, 13, 14, 15,
        16, 17, 18, 19, 20, 21, 23, 24, 25, 27, 29, 30,
        32, 34, 36, 38, 41, 43, 46, 48, 51, 55, 58, 61,
        65, 69, 73, 77, 82, 87, 92, 97, 103, 110, 116, 123,
        130, 138, 146, 155, 164, 174, 184, 195, 207, 220, 233, 246,
        261, 277, 293, 311, 329, 349, 369, 391, 415, 440, 466, 493,
        523, 554, 587, 622, 659, 698, 739, 783, 830, 880, 932, 987,
        1046, 1108, 1174, 1244, 1318, 1396, 1479, 1567, 1661, 1760, 1864, 1975,
        2093, 2217, 2349, 2489, 2637, 2793, 2959, 3135, 3322, 3520, 3729, 3951,
        4186, 4434, 4698, 4978, 5274, 5587, 5919, 6271, 6644, 7040, 7458, 7902,
        8372, 8869, 9397, 9956, 10548, 11175, 11839, 12543
    };

    class mix_scoreboard;
        logic [1:0]              wave_sel;
        logic [15:0]             voice_phase [VOICES];
        logic [6:0]              voice_note  [VOICES];
        logic [6:0]              voice_level [VOICES];
        logic signed [MIX_W-1:0] pending_samples [$];
        int                      mismatches;
        int                      sample_idx;

        function new();
            wave_sel   = WAVE_SQ25;
            mismatches = 0;
            sample_idx = 0;
            for (int v = 0; v < VOICES; v++)
            begin
                voice_phase[v] = '0;
                voice_note[v]  = '0;
                voice_level[v] = '0;
            end
        endfunction

        function void set_wave(logic [1:0] sel);
            wave_sel = sel;
        endfunction

        function int pending_count();
            return pending_samples.size();
        endfunction

        function logic [15:0] step_of(logic [6:0] n);
            longint prod;
            prod = longint'(NOTE_FREQ[n]) * PHASE_FULL;
            return 16'(prod / RATE_HZ);
        endfunction

        function int wave_at(logic [15:0] ph);
            int q, d, i, tri_v, sq50, sq25;
            q = 1 << (TABLE_BITS - 2);
            d = 16384 >> (TABLE_BITS - 2);
            i = int'(ph >> (16 - TABLE_BITS));
            if (i < 2 * q)
            begin
                tri_v = -16384 + i * d;
                sq50  = -16384;
                sq25  = -16384;
            end
            else if (i < 3 * q)
            begin
                tri_v = 16383 - (i - 2 * q) * d;
                sq50  = 16383;
                sq25  = -16384;
            end
            else
            begin
                tri_v = 16384 - (i - 2 * q) * d;
                sq50  = 16383;
                sq25  = 16383;
            end
            case (wave_sel)
                WAVE_TRI:  return tri_v;
                WAVE_SQ50: return sq50;
                default:   return sq25;
            endcase
        endfunction

        // update the voice mirror, and queue the expected sample, for one accepted request
        function void log_request(logic op, logic [7:0] st, logic [6:0] nn,
                                  logic [6:0] vel);
            int sum;
            bit hit;
            if (op == OP_TICK)
            begin
                sum = 0;
                for (int v = 0; v < VOICES; v++)
                begin
                    if (voice_level[v] != 0)
                    begin
                        sum += wave_at(voice_phase[v]);
                        voice_phase[v] = voice_phase[v] + step_of(voice_note[v]);
                    end
                end
                if (sum > MIX_MAX) sum = MIX_MAX;
                if (sum < MIX_MIN) sum = MIX_MIN;
                pending_samples.push_back(sum[MIX_W-1:0]);
            end
            else if (st == STATUS_NOTE_ON || st == STATUS_NOTE_OFF)
            begin
                hit = 1'b0;
                for (int v = 0; v < VOICES; v++)
                begin
                    if (voice_note[v] == nn)
                    begin
                        hit = 1'b1;
                        voice_level[v] = (st == STATUS_NOTE_OFF) ? 7'd0 : vel;
                    end
                end
                // unmatched note on claims the first silent voice, if any
                if (!hit && st == STATUS_NOTE_ON)
                begin
                    for (int v = 0; v < VOICES; v++)
                    begin
                        if (voice_level[v] == 0)
                        begin
                            voice_note[v]  = nn;
                            voice_level[v] = vel;
                            break;
                        end
                    end
                end
            end
        endfunction

        function void report_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("ERROR: %s", msg);
        endfunction

        function void check_sample(logic signed [MIX_W-1:0] got);
            logic signed [MIX_W-1:0] want;
            if (pending_samples.size() == 0)
                report_mismatch($sformatf("sample %0d: unexpected mix_sample %0d",
                                          sample_idx, got));
            else
            begin
                want = pending_samples.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("sample %0d: mix_sample %0d, expected %0d",
                                              sample_idx, got, want));
            end
            sample_idx++;
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic                    opcode;
    logic [7:0]              status;
    logic [6:0]              note_number;
    logic [6:0]              velocity;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [MIX_W-1:0] mix_sample;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [1:0]              cfg_data;

    bit                      long_hold_req;
    int                      cycle_count;
    mix_scoreboard           sb;

    poly_wavetable_voice_mixer #(
        .VOICES     (VOICES),
        .TABLE_BITS (TABLE_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .status      (status),
        .note_number (note_number),
        .velocity    (velocity),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mix_sample  (mix_sample),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_sample(mix_sample);
    end

    // sink: random ready pattern, plus one long hold-off on request
    initial
    begin : sink
        int run;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ready = 1'b0;
                run = LONG_HOLD;
            end
            else if ($urandom_range(0, 9) < 3)
            begin
                out_ready = 1'b0;
                run = $urandom_range(1, 6);
            end
            else
            begin
                out_ready = 1'b1;
                run = $urandom_range(1, 30);
            end
            repeat (run - 1) @(negedge clk);
        end
    end

    task automatic offer_request(logic op, logic [7:0] st, logic [6:0] nn,
                                 logic [6:0] vel);
        @(negedge clk);
        in_valid    = 1'b1;
        opcode      = op;
        status      = st;
        note_number = nn;
        velocity    = vel;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.log_request(op, st, nn, vel);
    endtask

    task automatic idle_gap(int cycles);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic write_wave(logic [1:0] sel);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = sel;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_wave(sel);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // wait for all samples, then let a trailing note event finish
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending_count() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(int target);
        int         counted;
        int         burst;
        int         r;
        logic       op;
        logic [7:0] st;
        logic [6:0] nn;
        logic [6:0] vel;
        counted = 0;
        while (counted < target)
        begin
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                r   = $urandom_range(0, 99);
                op  = OP_NOTE;
                st  = 8'($urandom);
                nn  = 7'($urandom);
                vel = 7'($urandom);
                if (r < 40)
                    op = OP_TICK;
                else if (r < 88)
                begin
                    st = ($urandom_range(0, 99) < 55) ? STATUS_NOTE_ON : STATUS_NOTE_OFF;
                    // small note pool so events find their voices again
                    if ($urandom_range(0, 9) < 8)
                        nn = 7'($urandom_range(48, 67));
                    if ($urandom_range(0, 9) == 0)
                        vel = '0;
                    else if (vel == 0)
                        vel = 7'd1;
                end
                else if (r < 94)
                    st = 8'($urandom_range(int'(STATUS_NOTE_OFF), 8'h9F));
                offer_request(op, st, nn, vel);
                counted++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_gap($urandom_range(1, 10));
        end
    endtask

    initial
    begin : stimulus
        logic [1:0] phase_wave [PHASE_COUNT];
        phase_wave = '{WAVE_TRI, WAVE_SQ50, WAVE_SPARE, WAVE_SQ25, WAVE_TRI};
        sb            = new();
        long_hold_req = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        opcode        = OP_TICK;
        status        = '0;
        note_number   = '0;
        velocity      = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed requests at the reset waveform
        offer_request(OP_TICK, 8'h00, 7'd0, 7'd0);
        offer_request(OP_NOTE, STATUS_NOTE_OFF, 7'd60, 7'd64);    // unmatched off
        offer_request(OP_NOTE, STATUS_NOTE_ON, 7'd60, 7'd127);    // claims voice 0
        offer_request(OP_TICK, 8'hFF, 7'd127, 7'd127);
        offer_request(OP_NOTE, STATUS_NOTE_ON, 7'd0, 7'd1);       // all reset voices
        offer_request(OP_TICK, 8'h00, 7'd0, 7'd0);
        offer_request(OP_TICK, 8'h00, 7'd0, 7'd0);
        offer_request(OP_NOTE, STATUS_NOTE_ON, 7'd61, 7'd10);     // no free voice
        offer_request(OP_NOTE, 8'h91, 7'd0, 7'd0);                // other channel
        offer_request(OP_NOTE, 8'hFF, 7'd60, 7'd0);
        offer_request(OP_NOTE, 8'h00, 7'd60, 7'd0);
        offer_request(OP_NOTE, STATUS_NOTE_ON, 7'd0, 7'd0);       // velocity 0 silences
        offer_request(OP_TICK, 8'h00, 7'd0, 7'd0);
        offer_request(OP_NOTE, STATUS_NOTE_ON, 7'd127, 7'd0);     // stored, silent
        offer_request(OP_NOTE, STATUS_NOTE_ON, 7'd127, 7'd127);
        offer_request(OP_NOTE, STATUS_NOTE_ON, 7'd69, 7'd100);
        offer_request(OP_TICK, 8'h00, 7'd0, 7'd0);
        offer_request(OP_TICK, 8'h00, 7'd0, 7'd0);
        offer_request(OP_NOTE, STATUS_NOTE_OFF, 7'd60, 7'd0);
        offer_request(OP_TICK, 8'h00, 7'd0, 7'd0);
        offer_request(OP_NOTE, STATUS_NOTE_OFF, 7'd127, 7'd127);
        offer_request(OP_TICK, 8'h00, 7'd0, 7'd0);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            settle();
            write_wave(phase_wave[p]);
            if (p == 2)
                long_hold_req = 1'b1;
            run_random(PHASE_ITEMS);
        end
        settle();

        if (sb.mismatches == 0 && sb.pending_count() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ----- poly_wavetable_voice_mixer.f -----
rtl/pwvm_pkg.sv
rtl/pwvm_ram.sv
rtl/poly_wavetable_voice_mixer.sv
verif/tb_top.sv
